// ----- rtl/core/cbg_pkg.sv -----
// Package for the RGB contrast / brightness / gamma core.
// Holds transaction types, register indexes, pipeline constants and the
// elaboration-time functions that build the log2 and exp2 constants.
`timescale 1ns / 1ps

package cbg_pkg;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pix_out_t;

    // register indexes on the write port
    localparam logic [2:0] REG_GAIN   = 3'd0;
    localparam logic [2:0] REG_BRIGHT = 3'd1;
    localparam logic [2:0] REG_RED    = 3'd2;
    localparam logic [2:0] REG_GREEN  = 3'd3;
    localparam logic [2:0] REG_BLUE   = 3'd4;
    localparam logic [2:0] REG_GAMMA  = 3'd5;

    localparam logic [23:0] GAIN_INF     = 24'hFFFFFF;
    localparam logic [23:0] GAIN_RST     = 24'd256;
    localparam logic [19:0] GAMMA_RST    = 20'd4096;
    localparam logic [15:0] FULL_LEVEL   = 16'd65280;

    // channel pipeline stages: product, level, log2 (17), magnitude, power, exp2 (17), output
    localparam int LOG_STAGES = 17;
    localparam int EXP_STAGES = 17;
    localparam int LATENCY    = 2 + LOG_STAGES + 2 + EXP_STAGES + 1;

    // floor square root, elaboration use only
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bit_v;
        rem   = x;
        root  = 64'd0;
        bit_v = 64'd1 << 62;
        while (bit_v > rem)
            bit_v = bit_v >> 2;
        while (bit_v != 64'd0)
        begin
            if (rem >= root + bit_v)
            begin
                rem  = rem - (root + bit_v);
                root = (root >> 1) + bit_v;
            end
            else
                root = root >> 1;
            bit_v = bit_v >> 2;
        end
        return root;
    endfunction

    // Q.30 constant 2^-(2^-k)
    function automatic logic [29:0] exp_coef(input int k);
        logic [63:0] c;
        c = 64'd1 << 29;
        for (int i = 1; i <= k; i++)
            c = isqrt64(c << 30);
        return c[29:0];
    endfunction

    // log2 in Q.16 by repeated squaring, elaboration use only
    function automatic logic [19:0] log2_q16(input logic [15:0] v);
        logic [3:0]  e;
        logic [15:0] frac;
        logic [63:0] m;
        e    = 4'd0;
        frac = 16'd0;
        for (int i = 1; i < 16; i++)
            if (v[i])
                e = 4'(i);
        m = 64'(v) << (30 - int'(e));
        for (int k = 1; k <= 16; k++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                frac[16 - k] = 1'b1;
            end
        end
        return {e, frac};
    endfunction

    localparam logic [19:0] LOG_FULL = log2_q16(FULL_LEVEL);

endpackage

// ----- rtl/core/cbg_log2.sv -----
// Pipelined log2 of a 16-bit level in Q.16, one squaring per stage.
// Depends on cbg_pkg.
`timescale 1ns / 1ps

module cbg_log2
    import cbg_pkg::*;
(
    input  logic        clk,
    input  logic [15:0] level,
    input  logic        zero,
    output logic [19:0] log_q16,
    output logic        zero_out
);

    logic [30:0] m_reg [0:LOG_STAGES-1];
    logic [15:0] f_reg [0:LOG_STAGES-1];
    logic [3:0]  e_reg [0:LOG_STAGES-1];
    logic        z_reg [0:LOG_STAGES-1];

    logic [3:0]  e_next;
    logic [30:0] m_next;

    // normalize: top set bit and mantissa in Q1.30
    always_comb
    begin
        e_next = 4'd0;
        for (int i = 1; i < 16; i++)
            if (level[i])
                e_next = 4'(i);
        m_next = 31'(level) << (5'd30 - 5'(e_next));
    end

    always_ff @(posedge clk)
    begin
        m_reg[0] <= m_next;
        f_reg[0] <= 16'd0;
        e_reg[0] <= e_next;
        z_reg[0] <= zero;
    end

    // one fraction bit per stage
    for (genvar k = 1; k < LOG_STAGES; k++)
    begin : g_sq
        localparam int BIT = 16 - k;
        logic [61:0] sq;
        logic [31:0] t;
        logic [15:0] f_next;

        always_comb
        begin
            sq = 62'(m_reg[k-1]) * 62'(m_reg[k-1]);
            t  = sq[61:30];
            f_next = f_reg[k-1];
            f_next[BIT] = t[31];
        end

        always_ff @(posedge clk)
        begin
            m_reg[k] <= t[31] ? t[31:1] : t[30:0];
            f_reg[k] <= f_next;
            e_reg[k] <= e_reg[k-1];
            z_reg[k] <= z_reg[k-1];
        end
    end

    assign log_q16  = {e_reg[LOG_STAGES-1], f_reg[LOG_STAGES-1]};
    assign zero_out = z_reg[LOG_STAGES-1];

endmodule

// ----- rtl/core/cbg_exp2.sv -----
// Pipelined 2^-f for a 16-bit fraction, Q.30, one constant multiply per stage.
// Depends on cbg_pkg.
`timescale 1ns / 1ps

module cbg_exp2
    import cbg_pkg::*;
(
    input  logic        clk,
    input  logic [15:0] frac,
    input  logic [3:0]  shift,
    input  logic        kill,
    output logic [30:0] pow_q30,
    output logic [3:0]  shift_out,
    output logic        kill_out
);

    logic [30:0] r_reg [0:EXP_STAGES-1];
    logic [15:0] f_reg [0:EXP_STAGES-1];
    logic [3:0]  s_reg [0:EXP_STAGES-1];
    logic        k_reg [0:EXP_STAGES-1];

    always_ff @(posedge clk)
    begin
        r_reg[0] <= 31'd1 << 30;
        f_reg[0] <= frac;
        s_reg[0] <= shift;
        k_reg[0] <= kill;
    end

    for (genvar k = 1; k < EXP_STAGES; k++)
    begin : g_mul
        localparam logic [29:0] COEF = exp_coef(k);
        localparam int BIT = 16 - k;
        logic [60:0] p;

        always_comb
            p = 61'(r_reg[k-1]) * 61'(COEF);

        always_ff @(posedge clk)
        begin
            r_reg[k] <= f_reg[k-1][BIT] ? p[60:30] : r_reg[k-1];
            f_reg[k] <= f_reg[k-1];
            s_reg[k] <= s_reg[k-1];
            k_reg[k] <= k_reg[k-1];
        end
    end

    assign pow_q30   = r_reg[EXP_STAGES-1];
    assign shift_out = s_reg[EXP_STAGES-1];
    assign kill_out  = k_reg[EXP_STAGES-1];

endmodule

// ----- rtl/core/cbg_channel.sv -----
// One color channel: contrast and offsets, clamp, log2, gamma power, exp2, scale.
// Depends on cbg_pkg, cbg_log2 and cbg_exp2.
`timescale 1ns / 1ps

module cbg_channel
    import cbg_pkg::*;
(
    input  logic               clk,
    input  logic [7:0]         pix,
    input  logic [23:0]        gain,
    input  logic signed [16:0] bright,
    input  logic signed [16:0] offs,
    input  logic [19:0]        gamma,
    output logic [7:0]         pix_out
);

    localparam logic signed [33:0] INF_POS = 34'sd4294967296;

    // stage 1: centered input times gain
    logic signed [8:0]  d;
    logic signed [33:0] prod_next, prod_reg;

    always_comb
    begin
        d = signed'({1'b0, pix}) - 9'sd128;
        if (gain == GAIN_INF)
            prod_next = (d > 9'sd0) ? INF_POS : ((d < 9'sd0) ? -INF_POS : 34'sd0);
        else
            prod_next = 34'(d) * signed'({10'd0, gain});
    end

    always_ff @(posedge clk)
        prod_reg <= prod_next;

    // stage 2: add offsets, clamp level
    logic signed [34:0] sum;
    logic [15:0] level_next, level_reg;
    logic        zero_next, zero_reg;

    always_comb
    begin
        sum = 35'(prod_reg) + 35'sd32768 + 35'(bright) + 35'(offs);
        zero_next  = (sum <= 35'sd0);
        if (zero_next)
            level_next = 16'd0;
        else if (sum > 35'(FULL_LEVEL))
            level_next = FULL_LEVEL;
        else
            level_next = sum[15:0];
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        zero_reg  <= zero_next;
    end

    logic [19:0] log_v;
    logic        zero_l;

    cbg_log2 u_log2 (
        .clk      (clk),
        .level    (level_reg),
        .zero     (zero_reg),
        .log_q16  (log_v),
        .zero_out (zero_l)
    );

    // magnitude of log2(level / full)
    logic [19:0] mag_reg;
    logic        zero_m_reg;

    always_ff @(posedge clk)
    begin
        mag_reg    <= (log_v < LOG_FULL) ? (LOG_FULL - log_v) : 20'd0;
        zero_m_reg <= zero_l;
    end

    // exponent n = gamma * mag, rounded to Q.16
    logic [39:0] gm;
    logic [40:0] nsum;
    logic [28:0] n;
    logic [15:0] n_frac_reg;
    logic [3:0]  n_int_reg;
    logic        kill_reg;

    always_comb
    begin
        gm   = 40'(gamma) * 40'(mag_reg);
        nsum = 41'(gm) + 41'd2048;
        n    = nsum[40:12];
    end

    always_ff @(posedge clk)
    begin
        n_frac_reg <= n[15:0];
        n_int_reg  <= n[19:16];
        kill_reg   <= zero_m_reg || (n[28:16] >= 13'd9);
    end

    logic [30:0] pw;
    logic [3:0]  sh;
    logic        kill_e;

    cbg_exp2 u_exp2 (
        .clk       (clk),
        .frac      (n_frac_reg),
        .shift     (n_int_reg),
        .kill      (kill_reg),
        .pow_q30   (pw),
        .shift_out (sh),
        .kill_out  (kill_e)
    );

    // integer part shift, scale by 255, round, clamp; zero gamma gives 255, kill gives 0
    logic [30:0] y;
    logic [39:0] scaled;
    logic [9:0]  q;
    logic [7:0]  out_next, out_reg;

    always_comb
    begin
        y      = pw >> sh;
        scaled = 40'(y) * 40'd255 + (40'd1 << 29);
        q      = scaled[39:30];
        if (gamma == 20'd0)
            out_next = 8'd255;
        else if (kill_e)
            out_next = 8'd0;
        else if (q > 10'd255)
            out_next = 8'd255;
        else
            out_next = q[7:0];
    end

    always_ff @(posedge clk)
        out_reg <= out_next;

    assign pix_out = out_reg;

endmodule

// ----- rtl/core/rgb_contrast_brightness_gamma_core.sv -----
// Top level of the RGB contrast / brightness / gamma core: registers,
// transaction valid line and three channel pipelines. Depends on cbg_pkg, cbg_channel.
//
//  port group               | direction | handshake
//  start / pixel_in         | in        | taken when start && !busy
//  done / result            | out       | one-cycle strobe, no back pressure
//  wr_en / wr_index/wr_data | in        | register write on wr_en
//
// One pixel per clock; each result follows its start through the product and level
// registers, 16-step log2 chain, magnitude and power, 16-step exp2 chain and output.
// busy is always low: the pipeline never stalls since results cannot be held.
// rst_n clears the valid line and loads register defaults.
`timescale 1ns / 1ps

module rgb_contrast_brightness_gamma_core
    import cbg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  pix_in_t     pixel_in,
    output logic        done,
    output pix_out_t    result,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [23:0] wr_data
);

    logic [23:0]        contrast_gain_reg;
    logic signed [16:0] brightness_reg;
    logic signed [16:0] red_offset_reg;
    logic signed [16:0] green_offset_reg;
    logic signed [16:0] blue_offset_reg;
    logic [19:0]        gamma_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contrast_gain_reg <= GAIN_RST;
            brightness_reg    <= 17'sd0;
            red_offset_reg    <= 17'sd0;
            green_offset_reg  <= 17'sd0;
            blue_offset_reg   <= 17'sd0;
            gamma_reg         <= GAMMA_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_GAIN:   contrast_gain_reg <= wr_data;
                REG_BRIGHT: brightness_reg    <= wr_data[16:0];
                REG_RED:    red_offset_reg    <= wr_data[16:0];
                REG_GREEN:  green_offset_reg  <= wr_data[16:0];
                REG_BLUE:   blue_offset_reg   <= wr_data[16:0];
                REG_GAMMA:  gamma_reg         <= wr_data[19:0];
                default:    ;
            endcase
        end
    end

    assign busy = 1'b0;

    // valid line alongside the channel pipelines
    logic [LATENCY-1:0] vld_reg, vld_next;

    always_comb
        vld_next = {vld_reg[LATENCY-2:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign done = vld_reg[LATENCY-1];

    cbg_channel u_red (
        .clk     (clk),
        .pix     (pixel_in.red_in),
        .gain    (contrast_gain_reg),
        .bright  (brightness_reg),
        .offs    (red_offset_reg),
        .gamma   (gamma_reg),
        .pix_out (result.red_out)
    );

    cbg_channel u_green (
        .clk     (clk),
        .pix     (pixel_in.green_in),
        .gain    (contrast_gain_reg),
        .bright  (brightness_reg),
        .offs    (green_offset_reg),
        .gamma   (gamma_reg),
        .pix_out (result.green_out)
    );

    cbg_channel u_blue (
        .clk     (clk),
        .pix     (pixel_in.blue_in),
        .gain    (contrast_gain_reg),
        .bright  (brightness_reg),
        .offs    (blue_offset_reg),
        .gamma   (gamma_reg),
        .pix_out (result.blue_out)
    );

    // every result traces back to a matching start
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without matching transaction");

    // zero gamma forces full scale on every channel
    a_gamma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && gamma_reg == 20'd0 |->
            result.red_out == 8'hFF && result.green_out == 8'hFF &&
            result.blue_out == 8'hFF)
        else $error("zero gamma did not give full scale");

    // infinite contrast drives a full-scale red input to full scale
    a_inf_gain: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(start && contrast_gain_reg == GAIN_INF &&
                      pixel_in.red_in == 8'hFF, LATENCY) |->
            result.red_out == 8'hFF)
        else $error("infinite contrast did not saturate");

endmodule

// ----- tb/sv/tb_rgb_contrast_brightness_gamma_core.sv -----
// Testbench for rgb_contrast_brightness_gamma_core: drives pixels and register writes,
// predicts each adjusted pixel in fixed point and checks every result strobe in order.
// Depends on cbg_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_rgb_contrast_brightness_gamma_core;
    import cbg_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    pix_in_t     pixel_in = '0;
    logic        done;
    pix_out_t    result;
    logic        wr_en = 1'b0;
    logic [2:0]  wr_index = REG_GAIN;
    logic [23:0] wr_data = '0;

    // local copy of the register file
    logic [23:0]        cfg_gain = GAIN_RST;
    logic signed [16:0] cfg_bright = '0;
    logic signed [16:0] cfg_red = '0;
    logic signed [16:0] cfg_green = '0;
    logic signed [16:0] cfg_blue = '0;
    logic [19:0]        cfg_gamma = GAMMA_RST;

    pix_in_t  pixel_queue[$];
    pix_out_t expected_pixels[$];
    logic [63:0] half_root[1:16];
    logic [19:0] log_full_level;
    int  send_idle_pct = 0;
    bit  taken = 1'b0;
    int  mismatches = 0;
    int  pixels_sent = 0;
    int  pixels_checked = 0;
    int  idle_cycles = 0;

    rgb_contrast_brightness_gamma_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .pixel_in(pixel_in),
        .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    always #5 clk = ~clk;

    // floor square root, bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    // log2 in Q.16 by repeated squaring of the normalized mantissa
    function automatic logic [19:0] level_log2(input logic [15:0] v);
        int          top;
        logic [15:0] frac;
        logic [63:0] m;
        top  = 0;
        frac = '0;
        for (int i = 1; i < 16; i++)
            if (v[i])
                top = i;
        m = 64'(v) << (30 - top);
        for (int k = 1; k <= 16; k++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                frac[16 - k] = 1'b1;
            end
        end
        return {4'(top), frac};
    endfunction

    // one channel: contrast, offsets, clamp, then gamma power
    function automatic logic [7:0] adjust_channel(input logic [7:0] x,
                                                  input logic signed [16:0] offs);
        longint      d;
        longint      lvl;
        longint      lg;
        logic [63:0] mag;
        logic [63:0] n;
        logic [63:0] y;
        logic [63:0] o;
        int          ip;
        d = longint'(x) - 128;
        if (cfg_gain == GAIN_INF)
            lvl = d > 0 ? (64'sd1 <<< 40) : (d < 0 ? -(64'sd1 <<< 40) : 0);
        else
            lvl = d * longint'(cfg_gain);
        lvl = lvl + 32768 + longint'(cfg_bright) + longint'(offs);
        if (lvl > longint'(FULL_LEVEL))
            lvl = longint'(FULL_LEVEL);
        if (cfg_gamma == '0)
            return 8'd255;
        if (lvl <= 0)
            return 8'd0;
        lg  = longint'(level_log2(16'(lvl))) - longint'(log_full_level);
        mag = lg < 0 ? 64'(-lg) : 64'd0;
        n   = (64'(cfg_gamma) * mag + 64'd2048) >> 12;
        ip  = int'(n >> 16);
        if (ip >= 9)
            return 8'd0;
        y = 64'd1 << 30;
        for (int k = 1; k <= 16; k++)
            if (n[16 - k])
                y = (y * half_root[k]) >> 30;
        y = y >> ip;
        o = (y * 64'd255 + (64'd1 << 29)) >> 30;
        return o > 64'd255 ? 8'd255 : o[7:0];
    endfunction

    function automatic pix_out_t adjust_pixel(input pix_in_t p);
        pix_out_t r;
        r.red_out   = adjust_channel(p.red_in, cfg_red);
        r.green_out = adjust_channel(p.green_in, cfg_green);
        r.blue_out  = adjust_channel(p.blue_in, cfg_blue);
        return r;
    endfunction

    // driver: present the next pixel, hold it until taken
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !taken)
            start <= 1'b1;
        else if (pixel_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)
        begin
            start    <= 1'b1;
            pixel_in <= pixel_queue.pop_front();
        end
        else
            start <= 1'b0;
    end

    // monitor: record accepted transactions, check result strobes, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            taken = start && !busy;
            if (taken)
            begin
                expected_pixels.push_back(adjust_pixel(pixel_in));
                pixels_sent++;
            end
            if (done)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with no pending pixel: %h", result);
                end
                else
                begin
                    pix_out_t exp_px;
                    exp_px = expected_pixels.pop_front();
                    pixels_checked++;
                    if (result.red_out !== exp_px.red_out ||
                        result.green_out !== exp_px.green_out ||
                        result.blue_out !== exp_px.blue_out)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch rgb: expected %0d %0d %0d got %0d %0d %0d",
                                     exp_px.red_out, exp_px.green_out, exp_px.blue_out,
                                     result.red_out, result.green_out, result.blue_out);
                    end
                end
            end
            idle_cycles = (taken || done) ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            REG_GAIN:   cfg_gain   = val;
            REG_BRIGHT: cfg_bright = val[16:0];
            REG_RED:    cfg_red    = val[16:0];
            REG_GREEN:  cfg_green  = val[16:0];
            REG_BLUE:   cfg_blue   = val[16:0];
            REG_GAMMA:  cfg_gamma  = val[19:0];
            default: ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pixel_queue.push_back('{red_in: r, green_in: g, blue_in: b});
    endtask

    // sender holds off until the pipeline has fully drained
    task automatic drain();
        while (pixel_queue.size() > 0 || start || expected_pixels.size() > 0)
            @(posedge clk);
    endtask

    function automatic logic [23:0] random_offset();
        int sel;
        sel = $urandom_range(9, 0);
        if (sel == 0)
            return 24'($urandom);
        if (sel == 1)
            return 24'($urandom_range(1, 0) ? 65280 : -65280);
        return 24'($signed($urandom_range(130560, 0)) - 65280);
    endfunction

    function automatic logic [23:0] random_gain();
        int sel;
        sel = $urandom_range(9, 0);
        if (sel == 0)
            return GAIN_INF;
        if (sel == 1)
            return 24'($urandom);
        return 24'($urandom_range(1024, 0));
    endfunction

    function automatic logic [23:0] random_gamma();
        int sel;
        sel = $urandom_range(19, 0);
        if (sel == 0)
            return 24'd0;
        if (sel < 3)
            return 24'($urandom_range(1048575, 1));
        return 24'($urandom_range(16384, 1));
    endfunction

    initial
    begin
        int idle_modes[4];
        idle_modes = '{0, 86, 0, 32};
        half_root[1] = floor_sqrt(64'd1 << 59);
        for (int k = 2; k <= 16; k++)
            half_root[k] = floor_sqrt(half_root[k - 1] << 30);
        log_full_level = level_log2(FULL_LEVEL);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: identity contrast, gamma one
        queue_pixel(8'd0, 8'd255, 8'd128);
        queue_pixel(8'd127, 8'd129, 8'd1);
        queue_pixel(8'd255, 8'd0, 8'd254);
        queue_pixel(8'haa, 8'h55, 8'hf0);
        drain();

        // infinite contrast around mid gray
        write_reg(REG_GAIN, GAIN_INF);
        queue_pixel(8'd127, 8'd128, 8'd129);
        queue_pixel(8'd0, 8'd255, 8'd128);
        drain();

        // offsets at and past the range, gamma zero
        write_reg(REG_BRIGHT, 24'd65280);
        write_reg(REG_RED, 24'(-65280));
        write_reg(REG_GREEN, 24'h00ffff);
        write_reg(REG_BLUE, 24'h010000);
        queue_pixel(8'd128, 8'd128, 8'd128);
        drain();
        write_reg(REG_GAMMA, 24'd0);
        queue_pixel(8'd128, 8'd0, 8'd255);
        queue_pixel(8'd0, 8'd0, 8'd0);
        drain();

        // largest and smallest gamma, zero gain
        write_reg(REG_GAIN, 24'd0);
        write_reg(REG_BRIGHT, 24'(-16384));
        write_reg(REG_RED, 24'd0);
        write_reg(REG_GREEN, 24'd0);
        write_reg(REG_BLUE, 24'd0);
        write_reg(REG_GAMMA, 24'hfffff);
        queue_pixel(8'd0, 8'd128, 8'd255);
        drain();
        write_reg(REG_GAMMA, 24'd1);
        write_reg(REG_GAIN, 24'd256);
        queue_pixel(8'd1, 8'd128, 8'd255);
        queue_pixel(8'd0, 8'd2, 8'd200);
        drain();
        write_reg(REG_GAMMA, 24'd9216);
        write_reg(REG_BRIGHT, 24'd0);
        queue_pixel(8'd1, 8'd10, 8'd100);
        queue_pixel(8'd255, 8'd254, 8'd3);
        drain();

        // random phases, new settings each phase
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_GAIN, random_gain());
            write_reg(REG_BRIGHT, random_offset());
            write_reg(REG_RED, random_offset());
            write_reg(REG_GREEN, random_offset());
            write_reg(REG_BLUE, random_offset());
            write_reg(REG_GAMMA, random_gamma());
            send_idle_pct = idle_modes[ph % 4];
            for (int i = 0; i < 48; i++)
                queue_pixel($urandom, $urandom, $urandom);
            drain();
        end

        repeat (LATENCY + 10) @(posedge clk);
        $display("covered %0d pixels over directed and 8 random register settings", pixels_sent);
        $display("checked %0d results, %0d mismatches", pixels_checked, mismatches);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
